### hdl/efla_pkg.sv
`default_nettype none
package efla_pkg;

    localparam int MAX_EXTENTS = 32;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int RESULT_CAP  = 32;
    localparam int PIECE_W     = $clog2(RESULT_CAP);

    localparam logic FUNC_RELEASE = 1'b0;
    localparam logic FUNC_TAKE    = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    typedef struct packed {
        logic [31:0] run_start;
        logic [15:0] run_length;
        logic        last;
        logic [15:0] taken_total;
        logic [31:0] free_total;
        logic [1:0]  status;
    } res_t;

endpackage
`default_nettype wire

### hdl/extent_free_list_allocator_unit.sv
// Flow: each pass reads every extent slot in index order, then applies one update in the
//   decide state; a release gives its item from the decide state, a take holds each piece until the next pass or flush.
// Input: one item at a time; a take of P pieces costs P passes plus one flush or one more
//   pass, and output stalls hold the decide and flush states. Each pass is set by the single
//   read port of the extent memories.
// Reset (aresetn low, synchronous): all valid bits, free total, state and output valid clear.
`default_nettype none
module extent_free_list_allocator_unit
    import efla_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [47:0]  s_tdata,   // block[31:0], count[47:32]
    input  wire         s_tuser,   // func
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [95:0] m_tdata,   // run_start[31:0], run_length[47:32],
                                   // taken_total[63:48], free_total[95:64]
    output logic        m_tlast,   // last
    output logic [1:0]  m_tuser    // status
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_FLUSH} state_t;

    localparam logic [IDX_W:0]   SCAN_N   = (IDX_W+1)'(MAX_EXTENTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_EXTENTS - 1);

    state_t             state_reg;
    logic [MAX_EXTENTS-1:0] vld_reg;
    logic [31:0]        sum_reg;
    logic               func_reg;
    logic [31:0]        blk_reg;
    logic [31:0]        len_reg;      // clipped release length
    logic [15:0]        cnt_reg;      // requested take count
    logic [15:0]        taken_reg;
    logic [PIECE_W-1:0] n_reg;

    // scan pointer and returned-data tag
    logic [IDX_W:0]     ptr_reg;
    logic               dv_reg;
    logic [IDX_W-1:0]   didx_reg;

    // scan trackers
    logic               pred_f_reg, suc_f_reg, hole_f_reg, best_f_reg, big_f_reg;
    logic [IDX_W-1:0]   pred_idx_reg, suc_idx_reg, hole_idx_reg, best_idx_reg, big_idx_reg;
    logic [31:0]        pred_begin_reg, pred_size_reg, suc_size_reg;
    logic [31:0]        best_begin_reg, best_size_reg, big_begin_reg, big_size_reg;

    // pending piece: held until the next pass tells whether it was the last
    logic               pend_f_reg;
    res_t               pend_reg;
    res_t               out_reg;
    logic               out_v_reg;

    // memory ports
    logic               b_we, s_we;
    logic [IDX_W-1:0]   waddr;
    logic [31:0]        b_wd, s_wd, rd_begin, rd_size;

    efla_ram #(.WIDTH(32), .DEPTH(MAX_EXTENTS)) u_begin_ram (
        .aclk(aclk), .we(b_we), .waddr(waddr), .wdata(b_wd),
        .raddr(ptr_reg[IDX_W-1:0]), .rdata(rd_begin)
    );

    efla_ram #(.WIDTH(32), .DEPTH(MAX_EXTENTS)) u_size_ram (
        .aclk(aclk), .we(s_we), .waddr(waddr), .wdata(s_wd),
        .raddr(ptr_reg[IDX_W-1:0]), .rdata(rd_size)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_reg.free_total, out_reg.taken_total,
                       out_reg.run_length, out_reg.run_start};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.status;

    // clip the released run so it ends at or below the top block
    logic [31:0] room, cnt_ext, len_clip;
    assign room     = ~s_tdata[31:0];
    assign cnt_ext  = {16'd0, s_tdata[47:32]};
    assign len_clip = (cnt_ext > room) ? room : cnt_ext;

    logic [31:0] after_blk;
    logic [15:0] rem;
    assign after_blk = blk_reg + len_reg;
    assign rem       = cnt_reg - taken_reg;

    // scan element qualifiers
    logic e_valid, e_pred, e_suc, e_best, e_big;
    always_comb begin
        e_valid = dv_reg && vld_reg[didx_reg];
        e_pred  = e_valid && (rd_begin < blk_reg) &&
                  (!pred_f_reg || rd_begin > pred_begin_reg);
        e_suc   = e_valid && !suc_f_reg && (rd_begin == after_blk);
        e_best  = e_valid && (rd_size >= {16'd0, rem}) &&
                  (!best_f_reg || rd_size < best_size_reg ||
                   (rd_size == best_size_reg && rd_begin < best_begin_reg));
        e_big   = e_valid &&
                  (!big_f_reg || rd_size > big_size_reg ||
                   (rd_size == big_size_reg && rd_begin < big_begin_reg));
    end

    // decide: one read-modify-write per pass
    logic               pred_ok, fin, cap, out_ld, pend_ld;
    logic [32:0]        pred_end, sum_add;
    logic [31:0]        sum_d, piece_start, best_left;
    logic [15:0]        piece_len, taken_d;
    logic [MAX_EXTENTS-1:0] vld_d;
    res_t               out_d, pend_d;
    state_t             dec_next;

    always_comb begin
        pred_end = {1'b0, pred_begin_reg} + {1'b0, pred_size_reg};
        pred_ok  = pred_f_reg && (pred_end == {1'b0, blk_reg});
        sum_add  = {1'b0, sum_reg} + {1'b0, len_reg};
        best_left = best_size_reg - {16'd0, rem};
        piece_start = best_f_reg ? best_begin_reg : big_begin_reg;
        piece_len   = best_f_reg ? rem : big_size_reg[15:0];
        taken_d     = taken_reg + piece_len;
        fin         = (taken_d >= cnt_reg);
        cap         = (n_reg == PIECE_W'(RESULT_CAP - 1));

        b_we = 1'b0;
        s_we = 1'b0;
        waddr = '0;
        b_wd = '0;
        s_wd = '0;
        vld_d = vld_reg;
        sum_d = sum_reg;
        out_ld = 1'b0;
        out_d = '0;
        pend_ld = 1'b0;
        pend_d = pend_reg;
        dec_next = S_IDLE;

        if (state_reg == S_DECIDE && !out_v_reg) begin
            out_ld = 1'b1;
            out_d.last = 1'b1;
            if (func_reg == FUNC_RELEASE) begin
                out_d.status = ST_OK;
                if (len_reg != '0) begin
                    if (pred_ok) begin
                        s_we  = 1'b1;
                        waddr = pred_idx_reg;
                        s_wd  = pred_size_reg + len_reg + (suc_f_reg ? suc_size_reg : 32'd0);
                        if (suc_f_reg) begin
                            vld_d[suc_idx_reg] = 1'b0;
                        end
                    end else if (suc_f_reg) begin
                        b_we  = 1'b1;
                        s_we  = 1'b1;
                        waddr = suc_idx_reg;
                        b_wd  = blk_reg;
                        s_wd  = suc_size_reg + len_reg;
                    end else if (hole_f_reg) begin
                        b_we  = 1'b1;
                        s_we  = 1'b1;
                        waddr = hole_idx_reg;
                        b_wd  = blk_reg;
                        s_wd  = len_reg;
                        vld_d[hole_idx_reg] = 1'b1;
                    end
                    if (pred_ok || suc_f_reg || hole_f_reg) begin
                        sum_d = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
                    end else begin
                        out_d.status = ST_DROP;
                    end
                end
                out_d.free_total = sum_d;
            end else if (cnt_reg == '0) begin
                out_d.free_total = sum_reg;
                out_d.status = ST_OK;
            end else if (!big_f_reg) begin
                // table ran dry: close out the pending piece, or report empty
                if (pend_f_reg) begin
                    out_d = pend_reg;
                    out_d.last = 1'b1;
                end else begin
                    out_d.free_total = sum_reg;
                end
                out_d.status = ST_SHORT;
            end else begin
                out_ld = pend_f_reg;
                out_d  = pend_reg;
                if (best_f_reg) begin
                    b_we  = 1'b1;
                    s_we  = 1'b1;
                    waddr = best_idx_reg;
                    b_wd  = best_begin_reg + {16'd0, rem};
                    s_wd  = best_left;
                    if (best_left == '0) begin
                        vld_d[best_idx_reg] = 1'b0;
                    end
                end else begin
                    vld_d[big_idx_reg] = 1'b0;
                end
                sum_d = (sum_reg > {16'd0, piece_len}) ? sum_reg - {16'd0, piece_len} : 32'd0;
                pend_ld = 1'b1;
                pend_d.run_start   = piece_start;
                pend_d.run_length  = piece_len;
                pend_d.last        = fin || cap;
                pend_d.taken_total = taken_d;
                pend_d.free_total  = sum_d;
                pend_d.status      = (cap && !fin) ? ST_SHORT : ST_OK;
                dec_next = (fin || cap) ? S_FLUSH : S_SCAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            vld_reg    <= '0;
            sum_reg    <= '0;
            out_v_reg  <= 1'b0;
            pend_f_reg <= 1'b0;
            dv_reg     <= 1'b0;
            ptr_reg    <= '0;
        end else begin
            // drop the output item once taken
            if (out_v_reg && m_tready) begin
                out_v_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        func_reg   <= s_tuser;
                        blk_reg    <= s_tdata[31:0];
                        len_reg    <= len_clip;
                        cnt_reg    <= s_tdata[47:32];
                        taken_reg  <= '0;
                        n_reg      <= '0;
                        pend_f_reg <= 1'b0;
                        ptr_reg    <= '0;
                        dv_reg     <= 1'b0;
                        pred_f_reg <= 1'b0;
                        suc_f_reg  <= 1'b0;
                        hole_f_reg <= 1'b0;
                        best_f_reg <= 1'b0;
                        big_f_reg  <= 1'b0;
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue reads in index order, qualify the returned data in the following cycle
                    if (ptr_reg < SCAN_N) begin
                        ptr_reg  <= ptr_reg + 1'b1;
                        dv_reg   <= 1'b1;
                        didx_reg <= ptr_reg[IDX_W-1:0];
                    end else begin
                        dv_reg <= 1'b0;
                    end
                    if (dv_reg && !vld_reg[didx_reg] && !hole_f_reg) begin
                        hole_f_reg   <= 1'b1;
                        hole_idx_reg <= didx_reg;
                    end
                    if (e_pred) begin
                        pred_f_reg     <= 1'b1;
                        pred_idx_reg   <= didx_reg;
                        pred_begin_reg <= rd_begin;
                        pred_size_reg  <= rd_size;
                    end
                    if (e_suc) begin
                        suc_f_reg    <= 1'b1;
                        suc_idx_reg  <= didx_reg;
                        suc_size_reg <= rd_size;
                    end
                    if (e_best) begin
                        best_f_reg     <= 1'b1;
                        best_idx_reg   <= didx_reg;
                        best_begin_reg <= rd_begin;
                        best_size_reg  <= rd_size;
                    end
                    if (e_big) begin
                        big_f_reg     <= 1'b1;
                        big_idx_reg   <= didx_reg;
                        big_begin_reg <= rd_begin;
                        big_size_reg  <= rd_size;
                    end
                    // the pointer has run out here, so the data tag clears above
                    if (dv_reg && didx_reg == LAST_IDX) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    // hold until the output register is free
                    if (!out_v_reg) begin
                        vld_reg <= vld_d;
                        sum_reg <= sum_d;
                        if (out_ld) begin
                            out_reg   <= out_d;
                            out_v_reg <= 1'b1;
                        end
                        if (pend_ld) begin
                            pend_reg   <= pend_d;
                            pend_f_reg <= 1'b1;
                            taken_reg  <= taken_d;
                            n_reg      <= n_reg + 1'b1;
                        end
                        ptr_reg    <= '0;
                        best_f_reg <= 1'b0;
                        big_f_reg  <= 1'b0;
                        state_reg  <= dec_next;
                    end
                end
                S_FLUSH: begin
                    if (!out_v_reg) begin
                        out_reg   <= pend_reg;
                        out_v_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### hdl/efla_ram.sv
`default_nettype none
module efla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
